>>> src/bmm_pkg.sv
// Shared types and constants for the bipartite matching block.
// Used by bmm_ctrl, bmm_dp and bipartite_max_matching; no dependencies.
package bmm_pkg;

  localparam int MAX_V = 16;
  localparam int VW    = 4;
  localparam int CW    = 5;

  localparam logic [CW-1:0] NO_PARTNER = 5'h1F;
  localparam logic [CW-1:0] INF_DIST   = 5'h1F;

  // configuration register indexes
  localparam logic REG_NUM_LEFT  = 1'b0;
  localparam logic REG_NUM_RIGHT = 1'b1;

  // datapath commands
  localparam logic [3:0] OP_LOAD  = 4'd0;
  localparam logic [3:0] OP_START = 4'd1;
  localparam logic [3:0] OP_BINIT = 4'd2;
  localparam logic [3:0] OP_BPOP  = 4'd3;
  localparam logic [3:0] OP_BSCAN = 4'd4;
  localparam logic [3:0] OP_DSEL  = 4'd5;
  localparam logic [3:0] OP_DTOP  = 4'd6;
  localparam logic [3:0] OP_DSCAN = 4'd7;
  localparam logic [3:0] OP_AUG   = 4'd8;
  localparam logic [3:0] OP_EMIT  = 4'd9;

  // outcome of one search step
  localparam logic [1:0] DFS_STEP  = 2'd0;
  localparam logic [1:0] DFS_PUSH  = 2'd1;
  localparam logic [1:0] DFS_FOUND = 2'd2;
  localparam logic [1:0] DFS_FAIL  = 2'd3;

  typedef struct packed {
    logic [VW-1:0] left_vertex;
    logic [15:0]   neighbours;
    logic          end_of_graph;
  } in_word_t;

  typedef struct packed {
    logic [VW-1:0] vertex_out;
    logic          is_matched;
    logic [VW-1:0] partner;
    logic [CW-1:0] matching_size;
    logic          last_result;
  } out_word_t;

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic       x_last;
    logic       x_done;
    logic       x_free;
    logic       q_empty;
    logic       skip;
    logic       path_seen;
    logic       y_last;
    logic [1:0] dfs;
    logic       top_zero;
    logic       emit_last;
  } status_t;

endpackage

>>> src/bmm_ctrl.sv
// Sequencer for the matching block: loading, BFS layering, DFS augmenting, result emission.
// Depends on bmm_pkg; drives commands into bmm_dp and reads its status.
module bmm_ctrl import bmm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    end_of_graph_i,
  input  status_t st_i,
  output cmd_t    cmd_o,
  output logic    in_stall_o
);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_BINIT = 4'd2;
  localparam logic [3:0] S_BPOP  = 4'd3;
  localparam logic [3:0] S_BSCAN = 4'd4;
  localparam logic [3:0] S_DSEL  = 4'd5;
  localparam logic [3:0] S_DTOP  = 4'd6;
  localparam logic [3:0] S_DSCAN = 4'd7;
  localparam logic [3:0] S_AUG   = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o.op = OP_LOAD;
    case (state_q)
      S_LOAD: begin
        cmd_o.op = OP_LOAD;
        if (in_valid_i && end_of_graph_i) state_d = S_START;
      end
      S_START: begin
        cmd_o.op = OP_START;
        state_d = S_BINIT;
      end
      S_BINIT: begin
        cmd_o.op = OP_BINIT;
        if (st_i.x_last) state_d = S_BPOP;
      end
      S_BPOP: begin
        cmd_o.op = OP_BPOP;
        if (st_i.q_empty) state_d = st_i.path_seen ? S_DSEL : S_EMIT;
        else if (!st_i.skip) state_d = S_BSCAN;
      end
      S_BSCAN: begin
        cmd_o.op = OP_BSCAN;
        if (st_i.y_last) state_d = S_BPOP;
      end
      S_DSEL: begin
        cmd_o.op = OP_DSEL;
        if (st_i.x_done) state_d = S_BINIT;
        else if (st_i.x_free) state_d = S_DTOP;
      end
      S_DTOP: begin
        cmd_o.op = OP_DTOP;
        state_d = S_DSCAN;
      end
      S_DSCAN: begin
        cmd_o.op = OP_DSCAN;
        case (st_i.dfs)
          DFS_PUSH:  state_d = S_DTOP;
          DFS_FOUND: state_d = S_AUG;
          DFS_FAIL:  state_d = st_i.top_zero ? S_DSEL : S_DTOP;
          default:   state_d = S_DSCAN;
        endcase
      end
      S_AUG: begin
        cmd_o.op = OP_AUG;
        if (st_i.top_zero) state_d = S_DSEL;
      end
      S_EMIT: begin
        cmd_o.op = OP_EMIT;
        if (st_i.emit_last) state_d = S_LOAD;
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/bmm_dp.sv
// Datapath for the matching block: adjacency rows, partner tables, layer distances,
// BFS queue, DFS stack, configuration and output register. Depends on bmm_pkg.
module bmm_dp import bmm_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_index_i,
  input  logic [CW-1:0] cfg_data_i,
  input  logic          in_valid_i,
  input  in_word_t      in_word_i,
  input  cmd_t          cmd_i,
  output status_t       st_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output out_word_t     out_word_o
);

  logic [15:0]   adj_q   [MAX_V];
  logic [CW-1:0] lp_q    [MAX_V];
  logic [CW-1:0] rp_q    [MAX_V];
  logic [CW-1:0] dist_q  [MAX_V];
  logic [VW-1:0] queue_q [MAX_V];
  logic [VW-1:0] stk_x_q [MAX_V+1];
  logic [CW-1:0] stk_y_q [MAX_V+1];

  logic [CW-1:0] num_left_q, num_right_q;
  logic [CW-1:0] nl, nr;
  logic [CW-1:0] xi_q, head_q, tail_q, top_q, y_q, pair_q, freed_q, dx_q;
  logic [VW-1:0] x_q;
  logic          out_valid_q;
  out_word_t     out_q;

  logic [16:0]   mask_w;
  logic          bit_w, w_m, out_free;
  logic [CW-1:0] w, dw, top_p1, top_m1;
  logic [CW:0]   dxp1;
  logic [VW-1:0] u_w;
  logic [1:0]    dfs_w;

  // clamp counts into 1..MAX_V
  assign nl = (num_left_q == '0) ? 5'd1 : (num_left_q > 5'(MAX_V)) ? 5'(MAX_V) : num_left_q;
  assign nr = (num_right_q == '0) ? 5'd1 : (num_right_q > 5'(MAX_V)) ? 5'(MAX_V) : num_right_q;
  assign mask_w = (17'd1 << nr) - 17'd1;

  assign bit_w  = adj_q[x_q][y_q[VW-1:0]];
  assign w      = rp_q[y_q[VW-1:0]];
  assign w_m    = (w != NO_PARTNER);
  assign dw     = dist_q[w[VW-1:0]];
  assign dxp1   = {1'b0, dx_q} + 6'd1;
  assign u_w    = queue_q[head_q[VW-1:0]];
  assign top_p1 = top_q + 5'd1;
  assign top_m1 = top_q - 5'd1;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    if (y_q >= nr) dfs_w = DFS_FAIL;
    else if (!bit_w) dfs_w = DFS_STEP;
    else if (w_m) begin
      dfs_w = (({1'b0, dw} == dxp1) && (top_q < 5'(MAX_V))) ? DFS_PUSH : DFS_STEP;
    end else begin
      dfs_w = ({1'b0, freed_q} == dxp1) ? DFS_FOUND : DFS_STEP;
    end
  end

  assign st_o.x_last    = (xi_q == nl - 5'd1);
  assign st_o.x_done    = (xi_q >= nl);
  assign st_o.x_free    = (lp_q[xi_q[VW-1:0]] == NO_PARTNER);
  assign st_o.q_empty   = (head_q == tail_q);
  assign st_o.skip      = (dist_q[u_w] >= freed_q);
  assign st_o.path_seen = (freed_q != INF_DIST);
  assign st_o.y_last    = (y_q == nr - 5'd1);
  assign st_o.dfs       = dfs_w;
  assign st_o.top_zero  = (top_q == '0);
  assign st_o.emit_last = out_free && (xi_q == nl - 5'd1);

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // stores with a reset value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_V; i++) begin
        adj_q[i] <= '0;
        lp_q[i]  <= NO_PARTNER;
        rp_q[i]  <= NO_PARTNER;
      end
      num_left_q  <= 5'(MAX_V);
      num_right_q <= 5'(MAX_V);
      pair_q      <= '0;
      freed_q     <= INF_DIST;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_NUM_LEFT) num_left_q <= cfg_data_i;
        else num_right_q <= cfg_data_i;
      end
      if (cmd_i.op == OP_EMIT && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      case (cmd_i.op)
        OP_LOAD: begin
          if (in_valid_i && ({1'b0, in_word_i.left_vertex} < nl)) begin
            adj_q[in_word_i.left_vertex] <= in_word_i.neighbours & mask_w[15:0];
          end
        end
        OP_START: begin
          for (int i = 0; i < MAX_V; i++) begin
            lp_q[i] <= NO_PARTNER;
            rp_q[i] <= NO_PARTNER;
          end
          pair_q  <= '0;
          freed_q <= INF_DIST;
        end
        OP_BSCAN: begin
          if (bit_w && !w_m && freed_q == INF_DIST) freed_q <= dxp1[CW-1:0];
        end
        OP_DSEL: begin
          if (xi_q >= nl) freed_q <= INF_DIST;
        end
        OP_AUG: begin
          lp_q[stk_x_q[top_q]] <= stk_y_q[top_q];
          rp_q[stk_y_q[top_q][VW-1:0]] <= {1'b0, stk_x_q[top_q]};
          if (top_q == '0) pair_q <= pair_q + 5'd1;
        end
        OP_EMIT: begin
          if (out_free) begin
            if (xi_q == nl - 5'd1) begin
              for (int i = 0; i < MAX_V; i++) adj_q[i] <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // working registers and scratch stores
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xi_q   <= '0;
      head_q <= '0;
      tail_q <= '0;
      top_q  <= '0;
      y_q    <= '0;
    end else begin
      case (cmd_i.op)
        OP_START: begin
          xi_q   <= '0;
          head_q <= '0;
          tail_q <= '0;
        end
        OP_BINIT: begin
          if (lp_q[xi_q[VW-1:0]] == NO_PARTNER) begin
            dist_q[xi_q[VW-1:0]]  <= '0;
            queue_q[tail_q[VW-1:0]] <= xi_q[VW-1:0];
            tail_q <= tail_q + 5'd1;
          end else begin
            dist_q[xi_q[VW-1:0]] <= INF_DIST;
          end
          xi_q <= xi_q + 5'd1;
        end
        OP_BPOP: begin
          if (head_q == tail_q) xi_q <= '0;
          else begin
            head_q <= head_q + 5'd1;
            x_q    <= u_w;
            dx_q   <= dist_q[u_w];
            y_q    <= '0;
          end
        end
        OP_BSCAN: begin
          if (bit_w && w_m && dw == INF_DIST && tail_q < 5'(MAX_V)) begin
            dist_q[w[VW-1:0]] <= dxp1[CW-1:0];
            queue_q[tail_q[VW-1:0]] <= w[VW-1:0];
            tail_q <= tail_q + 5'd1;
          end
          y_q <= y_q + 5'd1;
        end
        OP_DSEL: begin
          if (xi_q >= nl) begin
            xi_q   <= '0;
            head_q <= '0;
            tail_q <= '0;
          end else if (lp_q[xi_q[VW-1:0]] == NO_PARTNER) begin
            top_q      <= '0;
            stk_x_q[0] <= xi_q[VW-1:0];
            stk_y_q[0] <= '0;
          end else begin
            xi_q <= xi_q + 5'd1;
          end
        end
        OP_DTOP: begin
          x_q  <= stk_x_q[top_q];
          y_q  <= stk_y_q[top_q];
          dx_q <= dist_q[stk_x_q[top_q]];
        end
        OP_DSCAN: begin
          case (dfs_w)
            DFS_PUSH: begin
              stk_y_q[top_q]  <= y_q;
              stk_x_q[top_p1] <= w[VW-1:0];
              stk_y_q[top_p1] <= '0;
              top_q <= top_p1;
            end
            DFS_FOUND: begin
              stk_y_q[top_q] <= y_q;
            end
            DFS_FAIL: begin
              // dead end: drop this vertex from the layering and back up
              dist_q[x_q] <= INF_DIST;
              if (top_q == '0) xi_q <= xi_q + 5'd1;
              else begin
                top_q <= top_m1;
                stk_y_q[top_m1] <= stk_y_q[top_m1] + 5'd1;
              end
            end
            default: begin
              y_q <= y_q + 5'd1;
            end
          endcase
        end
        OP_AUG: begin
          if (top_q == '0) xi_q <= xi_q + 5'd1;
          else top_q <= top_m1;
        end
        OP_EMIT: begin
          if (out_free) begin
            out_q.vertex_out    <= xi_q[VW-1:0];
            out_q.is_matched    <= (lp_q[xi_q[VW-1:0]] != NO_PARTNER);
            out_q.partner       <= (lp_q[xi_q[VW-1:0]] != NO_PARTNER) ?
                                   lp_q[xi_q[VW-1:0]][VW-1:0] : '0;
            out_q.matching_size <= pair_q;
            out_q.last_result   <= (xi_q == nl - 5'd1);
            xi_q <= (xi_q == nl - 5'd1) ? '0 : xi_q + 5'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> src/bipartite_max_matching.sv
// Top level of the Hopcroft-Karp bipartite matching block.
// Depends on bmm_pkg, bmm_ctrl and bmm_dp.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o, in_word_i): one adjacency row per
//   word. Rows load at one word per cycle. The word with end_of_graph set
//   stores its row and starts the matching; the input stalls until all
//   results have been handed to the output register.
//   Output channel (out_valid_o / out_stall_i, out_word_o): one word per left
//   vertex 0..num_left-1 (clamped into 1..16), the last flagged by last_result.
//   Configuration (cfg_we_i, cfg_index_i, cfg_data_i): index 0 num_left,
//   index 1 num_right; write only while the block is idle.
// Search: one edge test per cycle in a single shared scan unit. A run
//   needs at most about 2*sqrt(V)+1 BFS plus DFS phases; results then
//   leave at one per cycle while the receiver takes them.
// Reset: adjacency cleared, counts 16, no result pending.
// A stalled receiver holds the output word and pauses emission; the rows of
// the next graph may load while the final result still waits.
module bipartite_max_matching import bmm_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_index_i,
  input  logic [CW-1:0] cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  in_word_t      in_word_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output out_word_t     out_word_o
);

  cmd_t    cmd;
  status_t st;
  logic    stall;

  bmm_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .end_of_graph_i (in_word_i.end_of_graph),
    .st_i           (st),
    .cmd_o          (cmd),
    .in_stall_o     (stall)
  );

  bmm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  assign in_stall_o = stall;

endmodule

>>> sim/tb.sv
// Testbench for bipartite_max_matching: random and directed graphs, checked
// against a Hopcroft-Karp matching predictor kept in the testbench.
// Depends on bmm_pkg and the bipartite_max_matching RTL.
`timescale 1ns / 100ps

module tb;
  import bmm_pkg::*;

  localparam int NONE    = -1;
  localparam int FAR     = 255;
  localparam int NUM_ITEMS = 210;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we_i = 1'b0;
  logic          cfg_index_i = REG_NUM_LEFT;
  logic [CW-1:0] cfg_data_i = '0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  in_word_t      in_word_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  out_word_t     out_word_o;

  bipartite_max_matching u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_word_i,
    .out_valid_o, .out_stall_i, .out_word_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic [15:0]   adj [MAX_V];
  int            lp [MAX_V];
  int            rp [MAX_V];
  int            layer_dist [MAX_V];
  int            free_dist;
  logic [CW-1:0] reg_left = 5'd16;
  logic [CW-1:0] reg_right = 5'd16;

  in_word_t  pending_rows [$];
  out_word_t expected_results [$];
  int        sender_idle = 0;
  int        recv_stall = 0;
  int        errors = 0;
  int        graphs_seen = 0;
  int        results_seen = 0;
  int        items_queued = 0;

  function automatic int clamp_count(logic [CW-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_V) return MAX_V;
    return int'(v);
  endfunction

  function automatic bit layer_search(int nl, int nr);
    int q [MAX_V];
    int head, tail, u, w;
    head = 0;
    tail = 0;
    for (int x = 0; x < nl; x++) begin
      if (lp[x] == NONE) begin
        layer_dist[x] = 0;
        q[tail++] = x;
      end else begin
        layer_dist[x] = FAR;
      end
    end
    free_dist = FAR;
    while (head < tail) begin
      u = q[head++];
      if (layer_dist[u] < free_dist) begin
        for (int y = 0; y < nr; y++) begin
          if (adj[u][y]) begin
            if (rp[y] != NONE) begin
              w = rp[y];
              if (layer_dist[w] == FAR && tail < MAX_V) begin
                layer_dist[w] = layer_dist[u] + 1;
                q[tail++] = w;
              end
            end else if (free_dist == FAR) begin
              free_dist = layer_dist[u] + 1;
            end
          end
        end
      end
    end
    return free_dist != FAR;
  endfunction

  function automatic bit augment(int root, int nr);
    int sx [MAX_V+1];
    int sy [MAX_V+1];
    int top, x, y, w;
    bit pushed, found;
    top = 0;
    sx[0] = root;
    sy[0] = 0;
    while (top >= 0) begin
      x = sx[top];
      y = sy[top];
      pushed = 0;
      found = 0;
      while (y < nr && !pushed && !found) begin
        if (adj[x][y]) begin
          if (rp[y] != NONE) begin
            w = rp[y];
            if (layer_dist[w] == layer_dist[x] + 1 && top < MAX_V) begin
              sy[top] = y;
              top++;
              sx[top] = w;
              sy[top] = 0;
              pushed = 1;
            end
          end else if (free_dist == layer_dist[x] + 1) begin
            sy[top] = y;
            found = 1;
          end
        end
        if (!pushed && !found) y++;
      end
      if (found) begin
        for (int k = top; k >= 0; k--) begin
          lp[sx[k]] = sy[k];
          rp[sy[k]] = sx[k];
        end
        return 1;
      end
      if (!pushed) begin
        layer_dist[x] = FAR;
        top--;
        if (top >= 0) sy[top] = (sy[top] + 1) & 8'hFF;
      end
    end
    return 0;
  endfunction

  // store the row; on the closing row compute the matching and queue results
  function automatic void predict_matching(in_word_t w);
    int nl, nr, pairs;
    logic [16:0] mask;
    out_word_t r;
    nl = clamp_count(reg_left);
    nr = clamp_count(reg_right);
    mask = (17'd1 << nr) - 17'd1;
    if (int'(w.left_vertex) < nl) adj[w.left_vertex] = w.neighbours & mask[15:0];
    if (!w.end_of_graph) return;
    for (int i = 0; i < MAX_V; i++) begin
      lp[i] = NONE;
      rp[i] = NONE;
    end
    pairs = 0;
    while (layer_search(nl, nr)) begin
      for (int x = 0; x < nl; x++)
        if (lp[x] == NONE && augment(x, nr)) pairs++;
    end
    for (int x = 0; x < nl; x++) begin
      r.vertex_out    = x[VW-1:0];
      r.is_matched    = lp[x] != NONE;
      r.partner       = (lp[x] != NONE) ? lp[x][VW-1:0] : '0;
      r.matching_size = pairs[CW-1:0];
      r.last_result   = (x == nl - 1);
      expected_results.push_back(r);
    end
    for (int i = 0; i < MAX_V; i++) adj[i] = '0;
    graphs_seen++;
  endfunction

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) predict_matching(in_word_i);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_rows.size() > 0 && $urandom_range(99) >= sender_idle) begin
          in_valid_i <= 1'b1;
          in_word_i  <= pending_rows.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word %p", out_word_o);
        end else if (out_word_o !== expected_results[0]) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %p got %p", expected_results[0], out_word_o);
          void'(expected_results.pop_front());
        end else begin
          void'(expected_results.pop_front());
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall);
    end
  end

  task automatic wait_drained();
    while (pending_rows.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [CW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_NUM_LEFT) reg_left = val;
    else reg_right = val;
  endtask

  task automatic add_row(logic [3:0] v, logic [15:0] n, logic eog);
    in_word_t w;
    w.left_vertex  = v;
    w.neighbours   = n;
    w.end_of_graph = eog;
    pending_rows.push_back(w);
    items_queued++;
  endtask

  // one graph of random rows; sparse, dense or plain rows, some out of range
  task automatic add_graph();
    int nl, rows, pick;
    logic [15:0] n;
    nl = clamp_count(reg_left);
    rows = $urandom_range(nl + 2, 1);
    for (int i = 0; i < rows; i++) begin
      pick = $urandom_range(3);
      n = 16'($urandom);
      if (pick == 0) n = n & 16'($urandom) & 16'($urandom);
      else if (pick == 1) n = n | 16'($urandom);
      add_row(($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(nl - 1)),
              n, i == rows - 1);
    end
  endtask

  task automatic set_idling();
    if (items_queued < NUM_ITEMS / 3) begin
      sender_idle = 16;
      recv_stall = 83;
    end else if (items_queued < 2 * NUM_ITEMS / 3) begin
      sender_idle = 83;
      recv_stall = 16;
    end else begin
      sender_idle = 0;
      recv_stall = 0;
    end
  endtask

  initial begin
    int settings [6][2] = '{'{0, 31}, '{31, 0}, '{1, 16}, '{16, 1}, '{5, 9}, '{17, 3}};
    for (int i = 0; i < MAX_V; i++) adj[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_idling();
    // directed: empty, full, diagonal, one shared column, ignored row closing
    add_row(4'd0, 16'h0000, 1'b1);
    add_row(4'd15, 16'hFFFF, 1'b1);
    for (int i = 0; i < 16; i++) add_row(4'(i), 16'h0001 << i, i == 15);
    add_row(4'd3, 16'h8000, 1'b0);
    add_row(4'd7, 16'h8000, 1'b1);
    wait_drained();
    write_reg(REG_NUM_LEFT, 5'd3);
    write_reg(REG_NUM_RIGHT, 5'd2);
    add_row(4'd0, 16'hFFFF, 1'b0);
    add_row(4'd9, 16'hFFFF, 1'b1);
    wait_drained();
    for (int p = 0; items_queued < NUM_ITEMS; p++) begin
      set_idling();
      if (p < 6) begin
        write_reg(REG_NUM_LEFT, 5'(settings[p][0]));
        write_reg(REG_NUM_RIGHT, 5'(settings[p][1]));
      end else if (p % 3 == 0) begin
        write_reg(REG_NUM_LEFT, 5'($urandom_range(31)));
        write_reg(REG_NUM_RIGHT, 5'($urandom_range(31)));
      end else if (p % 5 == 0) begin
        write_reg(REG_NUM_LEFT, 5'd16);
        write_reg(REG_NUM_RIGHT, 5'd16);
      end
      for (int g = 0; g < 3; g++) add_graph();
      wait_drained();
    end
    repeat (50) @(posedge clk_i);
    $display("Covered %0d graphs from %0d rows, %0d result words checked, %0d errors.",
             graphs_seen, items_queued, results_seen, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Timed out with %0d results outstanding.", expected_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> sim.f
src/bmm_pkg.sv
src/bmm_ctrl.sv
src/bmm_dp.sv
src/bipartite_max_matching.sv
sim/tb.sv
